// ===== design/text_line_number_and_escape_filter_core_assert.svh =====
// Assertion macros shared by the line-number and escape filter modules.
// Needs nothing else; each module that checks itself includes this file.
`ifndef TEXT_LINE_NUMBER_AND_ESCAPE_FILTER_CORE_ASSERT_SVH
`define TEXT_LINE_NUMBER_AND_ESCAPE_FILTER_CORE_ASSERT_SVH

// The consequence must hold in the same cycle as the antecedent.
`define TLNEF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in the line filter");

// The consequence must hold in the cycle after the antecedent.
`define TLNEF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed in the line filter");

`endif

// ===== design/tlnef_pkg.sv =====
// Shared types, character codes and the caret notation helper of the line filter.
// Depends on nothing; the front end, back end, top level and testbench use it by scoped names.
package tlnef_pkg;

  typedef struct packed {
    logic number_all_lines;
    logic number_nonblank_only;
    logic squeeze_blank_lines;
    logic mark_line_ends;
    logic mark_tabs;
    logic mark_nonprinting;
  } cfg_t;

  localparam int unsigned CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NUMBER_ALL      = 3'd0,
    REG_NUMBER_NONBLANK = 3'd1,
    REG_SQUEEZE         = 3'd2,
    REG_MARK_ENDS       = 3'd3,
    REG_MARK_TABS       = 3'd4,
    REG_MARK_NONPRINT   = 3'd5
  } cfg_reg_t;

  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_DOLLAR   = 8'h24;
  localparam logic [7:0] CH_CARET    = 8'h5E;
  localparam logic [7:0] CH_QUEST    = 8'h3F;
  localparam logic [7:0] CH_AT       = 8'h40;
  localparam logic [7:0] CH_M        = 8'h4D;
  localparam logic [7:0] CH_DASH     = 8'h2D;
  localparam logic [7:0] CH_I        = 8'h49;
  localparam logic [7:0] CH_DEL      = 8'h7F;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;

  // Narrowest field width of the line number.
  localparam int unsigned MIN_WIDTH = 6;

  // The body of one request: up to four bytes, sent from index 0 to last_idx.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
  } body_t;

  typedef enum logic [1:0] {
    PH_PAD,
    PH_DIGIT,
    PH_SEP,
    PH_BODY
  } phase_t;

  // Caret and M- notation of one byte; every low control value gets a caret.
  function automatic body_t caret_body(input logic [7:0] c);
    body_t      b;
    logic [6:0] low;
    logic [1:0] k;
    b.bytes    = '0;
    b.last_idx = 2'd0;
    low        = c[6:0];
    k          = 2'd0;
    if (c[7]) begin
      b.bytes[0] = CH_M;
      b.bytes[1] = CH_DASH;
      k          = 2'd2;
    end
    if ({1'b0, low} == CH_DEL) begin
      b.bytes[k]        = CH_CARET;
      b.bytes[k + 2'd1] = CH_QUEST;
      b.last_idx        = k + 2'd1;
    end else if ({1'b0, low} < CH_PRINT_LO) begin
      b.bytes[k]        = CH_CARET;
      b.bytes[k + 2'd1] = {1'b0, low} + CH_AT;
      b.last_idx        = k + 2'd1;
    end else begin
      b.bytes[k] = {1'b0, low};
      b.last_idx = k;
    end
    return b;
  endfunction

endpackage

// ===== design/tlnef_front.sv =====
// Front end of the line filter: takes input bytes, keeps the line state and counter,
// and builds one request per unsqueezed byte. Uses tlnef_pkg and the assertion header.
`include "text_line_number_and_escape_filter_core_assert.svh"

module tlnef_front #(
  parameter int unsigned LINE_DIGITS = 10,
  localparam int unsigned IW = $clog2(LINE_DIGITS),
  localparam int unsigned JOB_W = 1 + IW + 4 * LINE_DIGITS + $bits(tlnef_pkg::body_t)
) (
  input  logic              clk,
  input  logic              rst,
  input  tlnef_pkg::cfg_t   cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        byte_in,
  input  logic              q_full,
  output logic              push,
  output logic [JOB_W-1:0]  job
);

  typedef struct packed {
    logic                        prefix;
    logic [IW-1:0]               top;
    logic [LINE_DIGITS-1:0][3:0] digits;
    tlnef_pkg::body_t            body;
  } job_t;

  logic                        at_line_begin;
  logic                        previous_line_blank;
  logic [LINE_DIGITS-1:0][3:0] line_count_bcd;
  logic [LINE_DIGITS-1:0][3:0] line_count_bcd_next;
  logic [LINE_DIGITS-1:0][3:0] count_inc;
  logic [LINE_DIGITS-1:0]      nines;
  logic [LINE_DIGITS-1:0]      mask;
  logic                        carry;
  logic                        is_nl;
  logic                        is_tab;
  logic                        drop;
  logic                        count_en;
  logic                        accept;
  job_t                        job_d;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && !drop;
  assign job      = job_d;

  always_comb begin
    is_nl  = (byte_in == tlnef_pkg::CH_NL);
    is_tab = (byte_in == tlnef_pkg::CH_TAB);
    drop   = at_line_begin && cfg.squeeze_blank_lines && is_nl && previous_line_blank;
    count_en = at_line_begin && !drop &&
               (cfg.number_nonblank_only ? !is_nl : cfg.number_all_lines);

    // Decimal increment: a digit steps when every digit below it is a nine.
    mask  = '0;
    carry = 1'b0;
    for (int i = 0; i < LINE_DIGITS; i++) begin
      nines[i] = (line_count_bcd[i] == 4'd9);
    end
    for (int i = 0; i < LINE_DIGITS; i++) begin
      carry        = &(nines | ~mask);
      count_inc[i] = carry ? (nines[i] ? 4'd0 : line_count_bcd[i] + 4'd1)
                           : line_count_bcd[i];
      mask[i]      = 1'b1;
    end
    line_count_bcd_next = count_en ? count_inc : line_count_bcd;

    job_d        = '0;
    job_d.prefix = count_en;
    job_d.digits = line_count_bcd_next;
    for (int i = 1; i < LINE_DIGITS; i++) begin
      if (line_count_bcd_next[i] != 4'd0) begin
        job_d.top = IW'(i);
      end
    end

    priority if (is_nl) begin
      if (cfg.mark_line_ends) begin
        job_d.body.bytes[0] = tlnef_pkg::CH_DOLLAR;
        job_d.body.bytes[1] = tlnef_pkg::CH_NL;
        job_d.body.last_idx = 2'd1;
      end else begin
        job_d.body.bytes[0] = tlnef_pkg::CH_NL;
      end
    end else if (is_tab) begin
      if (cfg.mark_tabs) begin
        job_d.body.bytes[0] = tlnef_pkg::CH_CARET;
        job_d.body.bytes[1] = tlnef_pkg::CH_I;
        job_d.body.last_idx = 2'd1;
      end else begin
        job_d.body.bytes[0] = tlnef_pkg::CH_TAB;
      end
    end else if (cfg.mark_nonprinting &&
                 (byte_in < tlnef_pkg::CH_PRINT_LO || byte_in >= tlnef_pkg::CH_DEL)) begin
      job_d.body = tlnef_pkg::caret_body(byte_in);
    end else begin
      job_d.body.bytes[0] = byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_line_begin       <= 1'b1;
      previous_line_blank <= 1'b0;
      line_count_bcd      <= '0;
    end else if (accept) begin
      at_line_begin  <= is_nl;
      line_count_bcd <= line_count_bcd_next;
      if (at_line_begin) begin
        previous_line_blank <= cfg.squeeze_blank_lines && is_nl;
      end
    end
  end

  `TLNEF_ASSERT_NEXT(a_drop_keeps_line_begin, clk, rst, accept && drop,
                     at_line_begin && previous_line_blank)
  `TLNEF_ASSERT_NEXT(a_count_moves, clk, rst, accept && count_en,
                     line_count_bcd != $past(line_count_bcd))

endmodule

// ===== design/tlnef_queue.sv =====
// Two-entry queue that decouples the front end from the back end of the line filter.
// Uses the assertion header; the payload width comes from the instantiating module.
`include "text_line_number_and_escape_filter_core_assert.svh"

module tlnef_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] head
);

  logic [WIDTH-1:0] entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `TLNEF_ASSERT_NOW(a_no_overrun, clk, rst, push, !full)
  `TLNEF_ASSERT_NOW(a_no_underrun, clk, rst, pop, !empty)

endmodule

// ===== design/tlnef_back.sv =====
// Back end of the line filter: expands the queue head request into output bytes, one per
// cycle while out_ready is high, via a registered output. Uses tlnef_pkg, assert header.
`include "text_line_number_and_escape_filter_core_assert.svh"

module tlnef_back #(
  parameter int unsigned LINE_DIGITS = 10,
  localparam int unsigned IW = $clog2(LINE_DIGITS),
  localparam int unsigned JOB_W = 1 + IW + 4 * LINE_DIGITS + $bits(tlnef_pkg::body_t)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  logic [JOB_W-1:0] head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             last_of_run
);

  typedef struct packed {
    logic                        prefix;
    logic [IW-1:0]               top;
    logic [LINE_DIGITS-1:0][3:0] digits;
    tlnef_pkg::body_t            body;
  } job_t;

  job_t                      job;
  logic                      fresh;
  tlnef_pkg::phase_t         phase;
  tlnef_pkg::phase_t         phase_next;
  tlnef_pkg::phase_t         cur_phase;
  logic [IW-1:0]             idx;
  logic [IW-1:0]             idx_next;
  logic [IW-1:0]             cur_idx;
  logic [IW-1:0]             npad;
  logic [7:0]                byte_d;
  logic                      job_end;
  logic                      fire;

  assign job  = job_t'(head);
  assign fire = head_valid && (!out_valid || out_ready);
  assign pop  = fire && job_end;

  always_comb begin
    npad = (job.top < IW'(tlnef_pkg::MIN_WIDTH - 1))
           ? IW'(tlnef_pkg::MIN_WIDTH - 1) - job.top : '0;

    if (fresh) begin
      if (!job.prefix) begin
        cur_phase = tlnef_pkg::PH_BODY;
      end else if (npad != '0) begin
        cur_phase = tlnef_pkg::PH_PAD;
      end else begin
        cur_phase = tlnef_pkg::PH_DIGIT;
      end
      cur_idx = (cur_phase == tlnef_pkg::PH_DIGIT) ? job.top : '0;
    end else begin
      cur_phase = phase;
      cur_idx   = idx;
    end

    phase_next = cur_phase;
    idx_next   = cur_idx + IW'(1);
    job_end    = 1'b0;
    byte_d     = tlnef_pkg::CH_SPACE;

    unique case (cur_phase)
      tlnef_pkg::PH_PAD: begin
        if (cur_idx == npad - IW'(1)) begin
          phase_next = tlnef_pkg::PH_DIGIT;
          idx_next   = job.top;
        end
      end
      tlnef_pkg::PH_DIGIT: begin
        byte_d   = tlnef_pkg::CH_ZERO | {4'd0, job.digits[cur_idx]};
        idx_next = cur_idx - IW'(1);
        if (cur_idx == '0) begin
          phase_next = tlnef_pkg::PH_SEP;
          idx_next   = '0;
        end
      end
      tlnef_pkg::PH_SEP: begin
        if (cur_idx == IW'(1)) begin
          phase_next = tlnef_pkg::PH_BODY;
          idx_next   = '0;
        end
      end
      tlnef_pkg::PH_BODY: begin
        byte_d  = job.body.bytes[cur_idx[1:0]];
        job_end = (cur_idx[1:0] == job.body.last_idx);
      end
      default: begin
        job_end = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh     <= 1'b1;
      phase     <= tlnef_pkg::PH_PAD;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
        fresh     <= job_end;
        phase     <= phase_next;
        idx       <= idx_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte    <= byte_d;
      last_of_run <= job_end;
    end
  end

  `TLNEF_ASSERT_NEXT(a_pop_marks_last, clk, rst, pop, fresh && out_valid && last_of_run)
  `TLNEF_ASSERT_NOW(a_job_held_at_head, clk, rst, !fresh, head_valid)

endmodule

// ===== design/text_line_number_and_escape_filter_core.sv =====
// Top level of the line-number and caret-escape text filter.
// Uses tlnef_pkg, tlnef_front, tlnef_queue and tlnef_back.
//
// The filter takes one text byte per request and sends out the transformed bytes, one
// output byte per clock cycle while out_ready is high, with last_of_run marking the
// final byte of each request. An input byte that maps to a single output byte (the
// usual case) flows at one request per cycle while out_ready is high; a byte that
// expands to n output bytes holds the back end until all n are sent (up to four for
// an escape, plus the line-number prefix of max(digits, 6) + 2 bytes at the start of
// a numbered line), and the front end stalls once the two-entry queue between them is
// full. A squeezed blank line produces no output and takes no back-end time. The six
// configuration flags are written through cfg_we, cfg_index and cfg_data (bit 0), and
// should only change while the filter is idle. LINE_DIGITS sets the width of the
// decimal line counter, which wraps from all nines to zero.

module text_line_number_and_escape_filter_core #(
  parameter int unsigned LINE_DIGITS = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tlnef_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic                              cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        byte_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_byte,
  output logic                              last_of_run
);

  localparam int unsigned IW    = $clog2(LINE_DIGITS);
  localparam int unsigned JOB_W = 1 + IW + 4 * LINE_DIGITS + $bits(tlnef_pkg::body_t);

  tlnef_pkg::cfg_t  cfg;
  logic             q_full;
  logic             q_empty;
  logic             push;
  logic             pop;
  logic [JOB_W-1:0] job;
  logic [JOB_W-1:0] head;

  // Configuration flags. Writes to indexes past the last flag are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tlnef_pkg::REG_NUMBER_ALL:      cfg.number_all_lines     <= cfg_data;
        tlnef_pkg::REG_NUMBER_NONBLANK: cfg.number_nonblank_only <= cfg_data;
        tlnef_pkg::REG_SQUEEZE:         cfg.squeeze_blank_lines  <= cfg_data;
        tlnef_pkg::REG_MARK_ENDS:       cfg.mark_line_ends       <= cfg_data;
        tlnef_pkg::REG_MARK_TABS:       cfg.mark_tabs            <= cfg_data;
        tlnef_pkg::REG_MARK_NONPRINT:   cfg.mark_nonprinting     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The front end decides squeezing and numbering and builds the escape bytes.
  tlnef_front #(
    .LINE_DIGITS (LINE_DIGITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .byte_in  (byte_in),
    .q_full   (q_full),
    .push     (push),
    .job      (job)
  );

  // The queue lets a long expansion drain while the front end accepts until it is full.
  tlnef_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (job),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (head)
  );

  // The back end walks the prefix and body of each request a byte at a time.
  tlnef_back #(
    .LINE_DIGITS (LINE_DIGITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (!q_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for text_line_number_and_escape_filter_core.
// Needs tlnef_pkg and the filter RTL. A directed table runs first, then random text
// under several register settings, every output byte checked against the table or a model.

module tb_top;

  localparam int unsigned LINE_DIGITS = 10;
  // Covers the back end and the two-entry queue, with a good margin on top.
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_BYTES = 40;
  // Indexes past the last register; writes to them must change nothing.
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_byte_t;

  typedef enum logic {
    ROW_WRITE,
    ROW_BYTE
  } row_kind_t;

  // One line of the directed table: either a register write or a text byte. Where the
  // output can be read straight off the byte, it is typed in here and checked as given.
  typedef struct packed {
    row_kind_t       kind;
    logic [2:0]      index;
    logic            value;
    logic [7:0]      ch;
    logic            known;
    logic [2:0]      n_known;
    logic [3:0][7:0] known_bytes;
  } row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic       cfg_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] byte_in = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       last_of_run;

  text_line_number_and_escape_filter_core #(
    .LINE_DIGITS(LINE_DIGITS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .byte_in    (byte_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .last_of_run(last_of_run)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Our own copy of the filter: its flags, where it stands in the line, and the
  // decimal line count, least significant digit first.
  tlnef_pkg::cfg_t shadow_cfg;
  logic            at_line_begin;
  logic            line_was_blank;
  logic [3:0]      line_digits [LINE_DIGITS];

  // Bytes that the latest request turns into, and every byte still owed by the filter.
  text_byte_t rendered [$];
  text_byte_t expected_text [$];

  int   errors = 0;
  int   bytes_sent = 0;
  int   bytes_checked = 0;
  int   settings_used = 0;
  // While set, neither side idles.
  logic steady = 1'b0;

  function automatic void put_char(input logic [7:0] ch);
    rendered.push_back({ch, 1'b0});
  endfunction

  // Works out the output bytes of one accepted request and moves the line state on.
  function automatic void render_byte(input logic [7:0] c);
    logic       blank;
    logic       number_line;
    logic       carry;
    logic [7:0] low;
    int         i;
    int         top;
    text_byte_t tail;
    rendered.delete();
    if (at_line_begin) begin
      blank = (c == tlnef_pkg::CH_NL);
      if (shadow_cfg.squeeze_blank_lines && blank) begin
        // A second blank line in a row vanishes and leaves us at the line start.
        if (line_was_blank) begin
          return;
        end
        line_was_blank = 1'b1;
      end else begin
        line_was_blank = 1'b0;
      end
      // Numbering of non-blank lines only takes precedence over numbering every line.
      number_line = shadow_cfg.number_nonblank_only ? !blank : shadow_cfg.number_all_lines;
      if (number_line) begin
        carry = 1'b1;
        for (i = 0; i < LINE_DIGITS; i++) begin
          if (carry) begin
            if (line_digits[i] == 4'd9) begin
              line_digits[i] = 4'd0;
            end else begin
              line_digits[i] = line_digits[i] + 4'd1;
              carry = 1'b0;
            end
          end
        end
        top = 0;
        for (i = 1; i < LINE_DIGITS; i++) begin
          if (line_digits[i] != 4'd0) begin
            top = i;
          end
        end
        for (i = top + 1; i < int'(tlnef_pkg::MIN_WIDTH); i++) begin
          put_char(tlnef_pkg::CH_SPACE);
        end
        for (i = top; i >= 0; i--) begin
          put_char(tlnef_pkg::CH_ZERO + {4'd0, line_digits[i]});
        end
        put_char(tlnef_pkg::CH_SPACE);
        put_char(tlnef_pkg::CH_SPACE);
      end
      at_line_begin = 1'b0;
    end

    if (c == tlnef_pkg::CH_NL) begin
      if (shadow_cfg.mark_line_ends) begin
        put_char(tlnef_pkg::CH_DOLLAR);
      end
      put_char(tlnef_pkg::CH_NL);
      at_line_begin = 1'b1;
    end else if (c == tlnef_pkg::CH_TAB) begin
      if (shadow_cfg.mark_tabs) begin
        put_char(tlnef_pkg::CH_CARET);
        put_char(tlnef_pkg::CH_I);
      end else begin
        put_char(tlnef_pkg::CH_TAB);
      end
    end else if (shadow_cfg.mark_nonprinting &&
                 (c < tlnef_pkg::CH_PRINT_LO || c >= tlnef_pkg::CH_DEL)) begin
      // High bytes get M- and then their low seven bits, where tab and newline are
      // shown in caret form like any other control value.
      if (c[7]) begin
        put_char(tlnef_pkg::CH_M);
        put_char(tlnef_pkg::CH_DASH);
      end
      low = {1'b0, c[6:0]};
      if (low == tlnef_pkg::CH_DEL) begin
        put_char(tlnef_pkg::CH_CARET);
        put_char(tlnef_pkg::CH_QUEST);
      end else if (low < tlnef_pkg::CH_PRINT_LO) begin
        put_char(tlnef_pkg::CH_CARET);
        put_char(low + tlnef_pkg::CH_AT);
      end else begin
        put_char(low);
      end
    end else begin
      put_char(c);
    end

    tail = rendered.pop_back();
    tail.last = 1'b1;
    rendered.push_back(tail);
  endfunction

  function automatic row_t write_row(input logic [2:0] idx, input logic val);
    row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.index = idx;
    r.value = val;
    return r;
  endfunction

  function automatic row_t byte_row(input logic [7:0] ch);
    row_t r;
    r = '0;
    r.kind = ROW_BYTE;
    r.ch = ch;
    return r;
  endfunction

  function automatic row_t known_row(input logic [7:0] ch, input logic [2:0] n,
                                     input logic [7:0] b0, input logic [7:0] b1,
                                     input logic [7:0] b2, input logic [7:0] b3);
    row_t r;
    r = byte_row(ch);
    r.known = 1'b1;
    r.n_known = n;
    r.known_bytes = {b3, b2, b1, b0};
    return r;
  endfunction

  // Every task below that drives an input then waits at least one falling edge, so no
  // input ever gets two assignments in one time step.

  // Offers one byte and waits for the request to be taken, then records what it owes.
  task automatic send_byte(input logic [7:0] ch, input logic known, input logic [2:0] n_known,
                           input logic [3:0][7:0] known_bytes);
    in_valid <= 1'b1;
    byte_in <= ch;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    bytes_sent++;
    render_byte(ch);
    if (known) begin
      for (int k = 0; k < n_known; k++) begin
        expected_text.push_back({known_bytes[k], k == n_known - 1});
      end
    end else begin
      foreach (rendered[k]) begin
        expected_text.push_back(rendered[k]);
      end
    end
    @(negedge clk);
  endtask

  task automatic pause_input(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic maybe_pause();
    if (!steady && $urandom_range(0, 99) < 30) begin
      pause_input($urandom_range(1, 3));
    end
  endtask

  // Holds the sender back until every owed byte has come out, then lets a squeezed
  // line that yields nothing finish inside the filter as well.
  task automatic drain_filter();
    in_valid <= 1'b0;
    while (expected_text.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic write_reg(input logic [2:0] idx, input logic val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    case (idx)
      tlnef_pkg::REG_NUMBER_ALL:      shadow_cfg.number_all_lines = val;
      tlnef_pkg::REG_NUMBER_NONBLANK: shadow_cfg.number_nonblank_only = val;
      tlnef_pkg::REG_SQUEEZE:         shadow_cfg.squeeze_blank_lines = val;
      tlnef_pkg::REG_MARK_ENDS:       shadow_cfg.mark_line_ends = val;
      tlnef_pkg::REG_MARK_TABS:       shadow_cfg.mark_tabs = val;
      tlnef_pkg::REG_MARK_NONPRINT:   shadow_cfg.mark_nonprinting = val;
      default: ;
    endcase
  endtask

  // The receiver stalls about thirty percent of the time, except in the steady phase.
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 30);
  end

  // Every byte that leaves the filter must match the oldest byte still owed.
  always @(posedge clk) begin : check_output
    text_byte_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_text.size() == 0) begin
        errors++;
        $error("out_byte: expected nothing, got %02h", out_byte);
      end else begin
        want = expected_text.pop_front();
        bytes_checked++;
        if (out_byte !== want.ch) begin
          errors++;
          $error("out_byte: expected %02h, got %02h", want.ch, out_byte);
        end
        if (last_of_run !== want.last) begin
          errors++;
          $error("last_of_run: expected %0b, got %0b", want.last, last_of_run);
        end
      end
    end
  end

  initial begin : stimulus
    row_t            plan [$];
    row_t            row;
    tlnef_pkg::cfg_t next_cfg;
    logic [7:0]      b;
    logic            writing;
    logic            held;
    int              len;
    int              n_phase;

    shadow_cfg = '0;
    at_line_begin = 1'b1;
    line_was_blank = 1'b0;
    foreach (line_digits[i]) begin
      line_digits[i] = 4'd0;
    end

    // Straight after reset every flag is clear, so each byte passes unchanged.
    plan.push_back(known_row(8'h41, 3'd1, 8'h41, 8'h00, 8'h00, 8'h00));
    plan.push_back(known_row(8'h00, 3'd1, 8'h00, 8'h00, 8'h00, 8'h00));
    plan.push_back(known_row(8'hFF, 3'd1, 8'hFF, 8'h00, 8'h00, 8'h00));
    plan.push_back(known_row(tlnef_pkg::CH_NL, 3'd1, tlnef_pkg::CH_NL, 8'h00, 8'h00, 8'h00));
    // All three marking flags on: caret and M- forms, tab as caret I, dollar at line end.
    plan.push_back(write_row(tlnef_pkg::REG_MARK_NONPRINT, 1'b1));
    plan.push_back(write_row(tlnef_pkg::REG_MARK_TABS, 1'b1));
    plan.push_back(write_row(tlnef_pkg::REG_MARK_ENDS, 1'b1));
    plan.push_back(known_row(8'h00, 3'd2, tlnef_pkg::CH_CARET, tlnef_pkg::CH_AT,
                             8'h00, 8'h00));
    plan.push_back(known_row(8'h1F, 3'd2, tlnef_pkg::CH_CARET, 8'h5F, 8'h00, 8'h00));
    plan.push_back(known_row(tlnef_pkg::CH_DEL, 3'd2, tlnef_pkg::CH_CARET,
                             tlnef_pkg::CH_QUEST, 8'h00, 8'h00));
    plan.push_back(known_row(8'hFF, 3'd4, tlnef_pkg::CH_M, tlnef_pkg::CH_DASH,
                             tlnef_pkg::CH_CARET, tlnef_pkg::CH_QUEST));
    plan.push_back(known_row(8'h89, 3'd4, tlnef_pkg::CH_M, tlnef_pkg::CH_DASH,
                             tlnef_pkg::CH_CARET, tlnef_pkg::CH_I));
    plan.push_back(known_row(8'h8A, 3'd4, tlnef_pkg::CH_M, tlnef_pkg::CH_DASH,
                             tlnef_pkg::CH_CARET, 8'h4A));
    plan.push_back(known_row(8'hA0, 3'd3, tlnef_pkg::CH_M, tlnef_pkg::CH_DASH,
                             tlnef_pkg::CH_SPACE, 8'h00));
    plan.push_back(known_row(tlnef_pkg::CH_TAB, 3'd2, tlnef_pkg::CH_CARET, tlnef_pkg::CH_I,
                             8'h00, 8'h00));
    plan.push_back(known_row(tlnef_pkg::CH_NL, 3'd2, tlnef_pkg::CH_DOLLAR, tlnef_pkg::CH_NL,
                             8'h00, 8'h00));
    // With tab marking off and the other marking flags still on, a tab goes through as it is.
    plan.push_back(write_row(tlnef_pkg::REG_MARK_TABS, 1'b0));
    plan.push_back(known_row(tlnef_pkg::CH_TAB, 3'd1, tlnef_pkg::CH_TAB, 8'h00, 8'h00, 8'h00));
    // Numbering of every line with squeezing: the second blank line in a row disappears.
    plan.push_back(write_row(tlnef_pkg::REG_MARK_NONPRINT, 1'b0));
    plan.push_back(write_row(tlnef_pkg::REG_MARK_ENDS, 1'b0));
    plan.push_back(write_row(tlnef_pkg::REG_NUMBER_ALL, 1'b1));
    plan.push_back(write_row(tlnef_pkg::REG_SQUEEZE, 1'b1));
    plan.push_back(byte_row(8'h78));
    plan.push_back(byte_row(tlnef_pkg::CH_NL));
    plan.push_back(byte_row(tlnef_pkg::CH_NL));
    plan.push_back(byte_row(tlnef_pkg::CH_NL));
    // Both numbering flags set, so blank lines go unnumbered. Writes to the spare
    // indexes in between must not disturb anything.
    plan.push_back(write_row(tlnef_pkg::REG_NUMBER_NONBLANK, 1'b1));
    plan.push_back(write_row(REG_SPARE_LO, 1'b1));
    plan.push_back(write_row(REG_SPARE_HI, 1'b1));
    plan.push_back(byte_row(tlnef_pkg::CH_NL));
    plan.push_back(byte_row(8'h79));
    plan.push_back(byte_row(tlnef_pkg::CH_NL));
    plan.push_back(byte_row(tlnef_pkg::CH_NL));
    plan.push_back(byte_row(8'h80));
    plan.push_back(byte_row(tlnef_pkg::CH_NL));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    writing = 1'b0;
    settings_used = 1;
    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_WRITE) begin
        if (!writing) begin
          drain_filter();
          settings_used++;
        end
        write_reg(row.index, row.value);
        writing = 1'b1;
      end else begin
        if (writing) begin
          cfg_we <= 1'b0;
          @(negedge clk);
          writing = 1'b0;
        end
        maybe_pause();
        send_byte(row.ch, row.known, row.n_known, row.known_bytes);
      end
    end

    // Random text in short lines, each phase under its own flags: all set, all clear,
    // then random mixes. The third phase runs with no idling on either side.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) begin
        next_cfg = '1;
      end else if (p == 1) begin
        next_cfg = '0;
      end else begin
        next_cfg = tlnef_pkg::cfg_t'(6'($urandom_range(0, 63)));
      end
      drain_filter();
      if ($urandom_range(0, 1) == 1) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                  1'($urandom_range(0, 1)));
      end
      write_reg(tlnef_pkg::REG_NUMBER_ALL, next_cfg.number_all_lines);
      write_reg(tlnef_pkg::REG_NUMBER_NONBLANK, next_cfg.number_nonblank_only);
      write_reg(tlnef_pkg::REG_SQUEEZE, next_cfg.squeeze_blank_lines);
      write_reg(tlnef_pkg::REG_MARK_ENDS, next_cfg.mark_line_ends);
      write_reg(tlnef_pkg::REG_MARK_TABS, next_cfg.mark_tabs);
      write_reg(tlnef_pkg::REG_MARK_NONPRINT, next_cfg.mark_nonprinting);
      cfg_we <= 1'b0;
      @(negedge clk);
      settings_used++;

      steady = (p == 2);
      held = 1'b0;
      n_phase = 0;
      while (n_phase < PHASE_BYTES) begin
        // A quarter of the lines are empty, so blank runs and squeezing come up often.
        len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        for (int k = 0; k < len; k++) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: b = 8'($urandom_range(32, 126));
            4:          b = tlnef_pkg::CH_TAB;
            5:          b = 8'($urandom_range(0, 31));
            6:          b = tlnef_pkg::CH_DEL;
            7:          b = 8'($urandom_range(128, 255));
            default:    b = 8'($urandom_range(0, 255));
          endcase
          maybe_pause();
          send_byte(b, 1'b0, 3'd0, '0);
          n_phase++;
        end
        // Now and then a line runs on without its newline.
        if ($urandom_range(0, 9) != 0) begin
          maybe_pause();
          send_byte(tlnef_pkg::CH_NL, 1'b0, 3'd0, '0);
          n_phase++;
        end
        // Once, halfway through a phase, the sender waits for the filter to empty.
        if (p == 4 && !held && n_phase >= PHASE_BYTES / 2) begin
          drain_filter();
          held = 1'b1;
        end
      end
    end

    steady = 1'b0;
    drain_filter();

    $display("Sent %0d text bytes and checked %0d output bytes under %0d register settings,",
             bytes_sent, bytes_checked, settings_used);
    $display("switching numbering, squeezing and every marking flag both ways.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Far beyond the slowest correct run, even with every stall at its longest.
  initial begin : watchdog
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
